// ===== hw/rtl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants, the CORDIC arctangent table and the item record
// that travels alongside the quaternion to Euler angle datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

  // Width of the atan2 arguments, of the CORDIC datapath and of the angle.
  localparam int ARG_W = 34;
  localparam int CW    = ARG_W + 3;
  localparam int ZW    = 36;

  // Quotient bits of the asin argument and root digits of the cosine term.
  localparam int QB       = 31;
  localparam int SQ_STEPS = 31;

  localparam int ASIN_LAT   = QB + SQ_STEPS + 4;
  localparam int CORDIC_LAT = CORDIC_N + 1;
  localparam int SIDE_LEN   = ASIN_LAT + CORDIC_LAT;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;

  typedef struct packed {
    logic [15:0]             body_id;
    logic                    trk;
    logic signed [31:0]      px;
    logic signed [31:0]      py;
    logic signed [31:0]      pz;
    logic                    frame;
    logic                    euler;
    logic signed [15:0]      qw;
    logic signed [15:0]      qx;
    logic signed [15:0]      qy;
    logic signed [15:0]      qz;
    logic                    zero_n;
    logic                    north;
    logic                    south;
    logic signed [ARG_W-1:0] pit_y;
    logic signed [ARG_W-1:0] pit_x;
    logic signed [ARG_W-1:0] yaw_y;
    logic signed [ARG_W-1:0] yaw_x;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 36'sh03243F6A8;
      1:  v = 36'sh01DAC6705;
      2:  v = 36'sh00FADBAFC;
      3:  v = 36'sh007F56EA6;
      4:  v = 36'sh003FEAB76;
      5:  v = 36'sh001FFD55B;
      6:  v = 36'sh000FFFAAA;
      7:  v = 36'sh0007FFF55;
      8:  v = 36'sh0003FFFEA;
      9:  v = 36'sh0001FFFFD;
      10: v = 36'sh0000FFFFF;
      11: v = 36'sh00007FFFF;
      12: v = 36'sh00003FFFF;
      13: v = 36'sh00001FFFF;
      14: v = 36'sh00000FFFF;
      15: v = 36'sh000007FFF;
      16: v = 36'sh000003FFF;
      17: v = 36'sh000001FFF;
      18: v = 36'sh000000FFF;
      19: v = 36'sh0000007FF;
      20: v = 36'sh0000003FF;
      21: v = 36'sh0000001FF;
      22: v = 36'sh0000000FF;
      23: v = 36'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q2.30 radians to Q4.12, rounding half up and saturating.
  function automatic logic signed [15:0] to_q412(input logic signed [ZW:0] a);
    logic signed [ZW:0] t;
    logic signed [ZW:0] v;
    logic signed [15:0] r;
    t = a + (ZW+1)'(131072);
    v = t >>> 18;
    if (v > (ZW+1)'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -(ZW+1)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC atan2, one rotation per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic (
  input  logic                             clk,
  input  logic                             adv,
  input  logic signed [qte_pkg::ARG_W-1:0] y_in,
  input  logic signed [qte_pkg::ARG_W-1:0] x_in,
  output logic signed [qte_pkg::ZW-1:0]    z_out
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_r [0:CORDIC_N];
  logic signed [CW-1:0] y_r [0:CORDIC_N];
  logic signed [ZW-1:0] z_r [0:CORDIC_N];
  logic                 zero_r [0:CORDIC_N];

  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;

  assign xe = CW'(x_in);
  assign ye = CW'(y_in);

  // A vector in the left half plane is turned by pi before the rotations.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (x_in < 0) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        z_r[0] <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end
      zero_r[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!y_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  assign z_out = zero_r[CORDIC_N] ? '0 : z_r[CORDIC_N];

endmodule

`default_nettype wire

// ===== hw/rtl/qte_asin.sv =====
// ----------------------------------------------------------------------------
// qte_asin
// Forms the roll sine 2*pole/norm in Q1.30 with a pipelined restoring divider,
// then the matching cosine sqrt(1 - s^2) with a pipelined digit-by-digit root.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_asin (
  input  logic               clk,
  input  logic               adv,
  input  logic [32:0]        num_in,
  input  logic [32:0]        den_in,
  input  logic               neg_in,
  output logic signed [31:0] s_out,
  output logic [30:0]        c_out
);
  import qte_pkg::*;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Divider: the numerator is num_in * 2^30, and num_in never exceeds den_in.
  logic [32:0]   rem_r [0:QB];
  logic [QB-1:0] q_r   [0:QB];
  logic [32:0]   d_r   [0:QB];
  logic          neg_r [0:QB];
  logic          a0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= {1'b0, num_in[32:1]};
      a0_r     <= num_in[0];
      q_r[0]   <= '0;
      d_r[0]   <= den_in;
      neg_r[0] <= neg_in;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic        inb;
    logic [33:0] t;
    logic        ge;
    assign inb = (k == 0) ? a0_r : 1'b0;
    assign t   = {rem_r[k], inb};
    assign ge  = t >= {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= ge ? 33'(t - {1'b0, d_r[k]}) : t[32:0];
        q_r[k+1]   <= {q_r[k][QB-2:0], ge};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  // Sign, clamp, square and 1 - s^2.
  logic        [30:0] mag;
  logic signed [31:0] s1_r;
  logic signed [31:0] s2_r;
  logic signed [63:0] sq_full;
  logic        [61:0] sq_r;

  assign mag     = (q_r[QB] > ONE_Q30) ? ONE_Q30 : q_r[QB];
  assign sq_full = s1_r * s1_r;

  logic [61:0]        n_r    [0:SQ_STEPS];
  logic [32:0]        sr_r   [0:SQ_STEPS];
  logic [30:0]        root_r [0:SQ_STEPS];
  logic signed [31:0] sd_r   [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r      <= neg_r[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      sq_r      <= sq_full[61:0];
      s2_r      <= s1_r;
      n_r[0]    <= (62'd1 << 60) - sq_r;
      sr_r[0]   <= '0;
      root_r[0] <= '0;
      sd_r[0]   <= s2_r;
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    logic [34:0] t;
    logic [34:0] trial;
    logic        ge;
    assign t     = {sr_r[j], n_r[j][61:60]};
    assign trial = {2'b00, root_r[j], 2'b01};
    assign ge    = t >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        sr_r[j+1]   <= ge ? 33'(t - trial) : t[32:0];
        root_r[j+1] <= {root_r[j][29:0], ge};
        n_r[j+1]    <= {n_r[j][59:0], 2'b00};
        sd_r[j+1]   <= sd_r[j];
      end
    end
  end

  assign s_out = sd_r[SQ_STEPS];
  assign c_out = root_r[SQ_STEPS];

endmodule

`default_nettype wire

// ===== hw/rtl/quaternion_to_euler_converter.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_converter
// Turns one rigid body per item into one event, with the orientation
// passed through as a quaternion or converted to pitch, yaw and roll.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless the output stalls; the roll divider and
// square root, and the three CORDIC units, are fully pipelined with one bit or
// rotation per stage. A stalled output freezes the whole pipeline in place.
// Reset clears all valid bits and sets euler mode; data registers are not reset.
`default_nettype none

module quaternion_to_euler_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_body_id,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic               in_frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_body_tag,
  output logic               out_tracked,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [15:0] out_rot_w,
  output logic signed [15:0] out_rot_x,
  output logic signed [15:0] out_rot_y,
  output logic signed [15:0] out_rot_z,
  output logic               out_frame_last
);
  import qte_pkg::*;

  logic adv;
  logic euler_r;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      euler_r <= 1'b1;
    end else if (cfg_wr_en) begin
      euler_r <= cfg_wr_data;
    end
  end

  // Stage 1: component products.
  side_t              side1_nxt;
  side_t              side1_r;
  logic               vld1_r;
  logic signed [31:0] sw_r, sx_r, sy_r, sz_r;
  logic signed [31:0] pxy_r, pzw_r, pxw_r, pyz_r, pyw_r, pxz_r;

  always_comb begin
    side1_nxt         = '0;
    side1_nxt.body_id = in_body_id;
    side1_nxt.trk     = (in_pos_x != '0) || (in_pos_y != '0) || (in_pos_z != '0);
    side1_nxt.px      = in_pos_x;
    side1_nxt.py      = in_pos_y;
    side1_nxt.pz      = in_pos_z;
    side1_nxt.frame   = in_frame_end;
    side1_nxt.euler   = euler_r;
    side1_nxt.qw      = in_quat_w;
    side1_nxt.qx      = in_quat_x;
    side1_nxt.qy      = in_quat_y;
    side1_nxt.qz      = in_quat_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1_r <= side1_nxt;
      sw_r  <= in_quat_w * in_quat_w;
      sx_r  <= in_quat_x * in_quat_x;
      sy_r  <= in_quat_y * in_quat_y;
      sz_r  <= in_quat_z * in_quat_z;
      pxy_r <= in_quat_x * in_quat_y;
      pzw_r <= in_quat_z * in_quat_w;
      pxw_r <= in_quat_x * in_quat_w;
      pyz_r <= in_quat_y * in_quat_z;
      pyw_r <= in_quat_y * in_quat_w;
      pxz_r <= in_quat_x * in_quat_z;
    end
  end

  // Stage 2: norm, pole term and the atan2 arguments.
  side_t                   side2_r;
  logic                    vld2_r;
  logic signed [33:0]      norm2_r;
  logic signed [32:0]      pole2_r;
  logic signed [ARG_W-1:0] pit_y2_r, pit_x2_r, yaw_y2_r, yaw_x2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r  <= side1_r;
      norm2_r  <= 34'(sw_r) + 34'(sx_r) + 34'(sy_r) + 34'(sz_r);
      pole2_r  <= 33'(pxy_r) + 33'(pzw_r);
      pit_y2_r <= (ARG_W'(pxw_r) <<< 1) - (ARG_W'(pyz_r) <<< 1);
      pit_x2_r <= ARG_W'(sw_r) + ARG_W'(sy_r) - ARG_W'(sx_r) - ARG_W'(sz_r);
      yaw_y2_r <= (ARG_W'(pyw_r) <<< 1) - (ARG_W'(pxz_r) <<< 1);
      yaw_x2_r <= ARG_W'(sw_r) + ARG_W'(sx_r) - ARG_W'(sy_r) - ARG_W'(sz_r);
    end
  end

  // Stage 3: pole tests and the divider operands.
  logic signed [43:0] p1000;
  logic signed [43:0] n499;
  logic signed [32:0] pole_abs;
  logic               north, south;
  side_t              side3_nxt;
  side_t              side3_r;
  logic               vld3_r;
  logic [32:0]        num3_r;
  logic [32:0]        den3_r;
  logic               neg3_r;

  assign p1000    = 44'(pole2_r) * 44'sd1000;
  assign n499     = 44'(norm2_r) * 44'sd499;
  assign north    = p1000 > n499;
  assign south    = p1000 < -n499;
  assign pole_abs = pole2_r[32] ? -pole2_r : pole2_r;

  always_comb begin
    side3_nxt        = side2_r;
    side3_nxt.zero_n = (norm2_r == '0);
    side3_nxt.north  = north;
    side3_nxt.south  = south;
    side3_nxt.pit_y  = pit_y2_r;
    side3_nxt.pit_x  = pit_x2_r;
    // At a pole the yaw unit works on atan2(x, w) instead.
    if (north || south) begin
      side3_nxt.yaw_y = ARG_W'(side2_r.qx);
      side3_nxt.yaw_x = ARG_W'(side2_r.qw);
    end else begin
      side3_nxt.yaw_y = yaw_y2_r;
      side3_nxt.yaw_x = yaw_x2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side3_r <= side3_nxt;
      num3_r  <= {pole_abs[31:0], 1'b0};
      den3_r  <= norm2_r[32:0];
      neg3_r  <= pole2_r[32];
    end
  end

  // Roll sine and cosine.
  logic signed [31:0] s_asin;
  logic [30:0]        c_asin;

  qte_asin u_asin (
    .clk    (clk),
    .adv    (adv),
    .num_in (num3_r),
    .den_in (den3_r),
    .neg_in (neg3_r),
    .s_out  (s_asin),
    .c_out  (c_asin)
  );

  // Item record and valid bits alongside the divider, root and CORDIC stages.
  side_t side_r [0:SIDE_LEN-1];
  logic  vld_r  [0:SIDE_LEN-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side3_r;
      for (int k = 1; k < SIDE_LEN; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SIDE_LEN; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= vld3_r;
      for (int k = 1; k < SIDE_LEN; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  side_t side_a;
  assign side_a = side_r[ASIN_LAT-1];

  logic signed [ZW-1:0] z_pit, z_yaw, z_rol;

  qte_cordic u_cordic_pitch (
    .clk   (clk),
    .adv   (adv),
    .y_in  (side_a.pit_y),
    .x_in  (side_a.pit_x),
    .z_out (z_pit)
  );

  qte_cordic u_cordic_yaw (
    .clk   (clk),
    .adv   (adv),
    .y_in  (side_a.yaw_y),
    .x_in  (side_a.yaw_x),
    .z_out (z_yaw)
  );

  qte_cordic u_cordic_roll (
    .clk   (clk),
    .adv   (adv),
    .y_in  (ARG_W'(s_asin)),
    .x_in  (ARG_W'({1'b0, c_asin})),
    .z_out (z_rol)
  );

  // Output stage.
  side_t              side_c;
  logic signed [ZW:0] yaw2;
  logic signed [15:0] rw_nxt, rx_nxt, ry_nxt, rz_nxt;

  assign side_c = side_r[SIDE_LEN-1];
  assign yaw2   = (ZW+1)'(z_yaw) <<< 1;

  always_comb begin
    rw_nxt = '0;
    rx_nxt = '0;
    ry_nxt = '0;
    rz_nxt = '0;
    if (side_c.trk) begin
      if (!side_c.euler) begin
        rw_nxt = side_c.qw;
        rx_nxt = side_c.qx;
        ry_nxt = side_c.qy;
        rz_nxt = side_c.qz;
      end else if (side_c.zero_n) begin
        rx_nxt = '0;
      end else if (side_c.north) begin
        ry_nxt = to_q412(yaw2);
        rz_nxt = to_q412((ZW+1)'(HALF_PI_Q30));
      end else if (side_c.south) begin
        ry_nxt = to_q412(-yaw2);
        rz_nxt = to_q412(-(ZW+1)'(HALF_PI_Q30));
      end else begin
        rx_nxt = to_q412((ZW+1)'(z_pit));
        ry_nxt = to_q412((ZW+1)'(z_yaw));
        rz_nxt = to_q412((ZW+1)'(z_rol));
      end
    end
  end

  logic [15:0]        tag_r;
  logic               trk_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic signed [15:0] rw_r, rx_r, ry_r, rz_r;
  logic               last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[SIDE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r  <= side_c.body_id;
      trk_r  <= side_c.trk;
      ox_r   <= side_c.px;
      oy_r   <= side_c.py;
      oz_r   <= side_c.pz;
      rw_r   <= rw_nxt;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      rz_r   <= rz_nxt;
      last_r <= side_c.frame;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_body_tag   = tag_r;
  assign out_tracked    = trk_r;
  assign out_x          = ox_r;
  assign out_y          = oy_r;
  assign out_z          = oz_r;
  assign out_rot_w      = rw_r;
  assign out_rot_x      = rx_r;
  assign out_rot_y      = ry_r;
  assign out_rot_z      = rz_r;
  assign out_frame_last = last_r;

  // An untracked item carries nothing but its tag and frame marker.
  a_untracked_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !trk_r |-> ox_r == '0 && oy_r == '0 && oz_r == '0 &&
      rw_r == '0 && rx_r == '0 && ry_r == '0 && rz_r == '0)
    else $error("untracked item with nonzero values");

  // A tracked item has a nonzero position.
  a_tracked_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && trk_r |-> ox_r != '0 || oy_r != '0 || oz_r != '0)
    else $error("tracked item with zero position");

  // Reset empties the output stage.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

`default_nettype wire
